// ===== rtl/vobi_pkg.sv =====
// Types and constants shared by the variable-length block offset index builder.
package vobi_pkg;

    localparam int LEN_W = 24;
    localparam int CNT_W = 13;
    localparam int IDX_W = 12;
    localparam int SCR_W = 14;
    localparam int IN_W  = 40;
    localparam int OUT_W = 88;

    localparam logic [LEN_W-1:0] MAX_BUF_RST = 24'd65536;
    localparam logic [SCR_W-1:0] SCRATCH_RST = 14'd8192;

    // x / 3 == (x * 43691) >> 17 for every x below 2**16
    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam logic REG_MAX_BUF = 1'b0;
    localparam logic REG_SCRATCH = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef struct packed {
        logic             wide;
        logic [CNT_W-1:0] count;
        logic [LEN_W-1:0] blen;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] offset;
        logic [1:0]       status;
    } t_result;

endpackage

// ===== rtl/varblock_offset_index_builder_core.sv =====
// Block builder top level: offset table memory, start, append checks, read-back and finish.
//
//  Channel  | Dir | Handshake                  | Payload
//  ---------+-----+----------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | action, item_len, item_index
//  m_axis   | out | m_axis_tvalid/m_axis_tready | status, offsets, lengths, count, mode
//  apb      | in  | psel/penable/pwrite/pready  | max_buffer_len @0x0, scratch_len @0x4
//
// Start and finish are answered from the calc state; append and read go on to the final state.
// The offset table is one memory with a single registered read port, so a read
// fetches the item's entry on accept and the next entry in the calc state.
// One beat is in flight at a time; s_axis_tready is high only when no beat is at work.
// A finished result waits in the output register, and the next beat may be taken meanwhile.
// Reset clears count, sum and mode, presets limit and registers; the table needs no clearing.
module varblock_offset_index_builder_core
    import vobi_pkg::*;
#(
    parameter int TABLE_DEPTH        = 4096,
    parameter int HEADER_BYTES       = 8,
    parameter int SMALL_OFFSET_LIMIT = 64512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] action, [25:2] item_len, [37:26] item_index, [39:38] zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [1:0] status, [25:2] item_offset, [49:26] item_length, [73:50] block_len,
    // [86:74] item_count, [87] wide_offsets
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [16:0]      DEPTH_V   = 17'(TABLE_DEPTH);
    localparam logic [26:0]      HDR_V     = 27'(HEADER_BYTES);
    localparam logic [26:0]      SOL_V     = 27'(SMALL_OFFSET_LIMIT);
    localparam logic [CNT_W-1:0] HALF_RST  = 13'(SCRATCH_RST >> 1);
    localparam logic [CNT_W-1:0] LIMIT_RST =
        (TABLE_DEPTH < int'(SCRATCH_RST >> 1)) ? 13'(TABLE_DEPTH) : HALF_RST;

    function automatic logic [CNT_W-1:0] clamp_lim(input logic [CNT_W-1:0] v);
        if ({4'b0, v} > DEPTH_V) begin
            return 13'(TABLE_DEPTH);
        end
        return v;
    endfunction

    function automatic logic [26:0] even_up(input logic [26:0] x);
        logic [26:0] s;
        s = x + 27'd1;
        return {s[26:1], 1'b0};
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [16:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[AW-1:0];
    endfunction

    // control state
    t_state           r_state, n_state;
    logic             r_o_valid, n_o_valid;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len_sum, n_len_sum;
    logic             r_large, n_large;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic [LEN_W-1:0] r_max_buf;
    logic [SCR_W-1:0] r_scratch;

    // payload
    t_result          r_o_data, n_o_data;
    t_action          r_act;
    logic [LEN_W-1:0] r_ilen;
    logic [IDX_W-1:0] r_idx;
    logic [26:0]      r_next_off;
    logic [26:0]      r_new_sum;
    logic [15:0]      r_tail_s;
    logic [15:0]      r_tail_w;
    logic [CNT_W-1:0] r_div3;
    logic [LEN_W-1:0] r_off0;

    // offset table
    logic [LEN_W-1:0] mem [TABLE_DEPTH];
    logic [LEN_W-1:0] r_rdata;
    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;

    logic             accept, out_free, cfg_wr;
    t_action          in_act;
    logic [IDX_W-1:0] in_idx;

    // calc-stage terms
    logic [26:0]      c_next_off, c_new_sum, c_blen;
    logic [16:0]      c_cnt3, c_cnt_m;
    logic [15:0]      c_tail_s, c_tail_w;
    logic [29:0]      c_prod;

    // final-stage terms
    logic             f_small, f_fail, f_bad, f_use_next;
    logic [26:0]      f_total, f_end, f_len;
    logic [CNT_W-1:0] f_lim3;
    logic [16:0]      f_idx1;
    logic             start_commit;

    assign in_act        = t_action'(s_axis_tdata[1:0]);
    assign in_idx        = s_axis_tdata[37:26];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_o_valid || m_axis_tready;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;

    assign prdata = (paddr[2] == REG_SCRATCH) ? {18'b0, r_scratch} : {8'b0, r_max_buf};

    assign c_next_off = HDR_V + 27'(r_len_sum);
    assign c_new_sum  = 27'(r_len_sum) + 27'(r_ilen);
    assign c_tail_s   = 16'({r_count, 1'b0}) + 16'd2;
    assign c_cnt3     = (17'(r_count) + 17'd1) * 17'd3;
    assign c_tail_w   = 16'(even_up(27'(c_cnt3)));
    assign c_prod     = 30'(r_scratch) * 30'(DIV3_MUL);
    assign c_cnt_m    = r_large ? 17'(r_count) * 17'd3 : {3'b0, r_count, 1'b0};
    assign c_blen     = HDR_V + even_up(27'(r_len_sum)) + even_up(27'(c_cnt_m));

    assign f_small = !r_large && (r_next_off <= SOL_V);
    assign f_total = HDR_V + even_up(r_new_sum) + (f_small ? 27'(r_tail_s) : 27'(r_tail_w));
    assign f_lim3  = clamp_lim(r_div3);
    assign f_fail  = (r_count >= r_limit) || (f_total > 27'(r_max_buf))
                  || (!f_small && !r_large && (r_count >= f_lim3));

    assign f_idx1     = 17'(r_idx) + 17'd1;
    assign f_bad      = (13'(r_idx) >= r_count) || (17'(r_idx) >= DEPTH_V);
    assign f_use_next = (f_idx1 < 17'(r_count)) && (f_idx1 < DEPTH_V);
    assign f_end      = f_use_next ? 27'(r_rdata) : HDR_V + 27'(r_len_sum);
    assign f_len      = f_end - 27'(r_off0);

    assign start_commit = (r_state == S_CALC) && (r_act == ACT_START) && out_free;

    always_comb begin
        n_state   = r_state;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_o_data  = r_o_data;
        n_count   = r_count;
        n_len_sum = r_len_sum;
        n_large   = r_large;
        n_limit   = r_limit;
        rd_en     = 1'b0;
        rd_addr   = to_addr({5'b0, in_idx});
        wr_en     = 1'b0;
        wr_addr   = to_addr({4'b0, r_count});
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CALC;
                    rd_en   = (in_act == ACT_READ);
                end
            end
            S_CALC: begin
                unique case (r_act)
                    ACT_START: begin
                        if (out_free) begin
                            n_count   = '0;
                            n_len_sum = '0;
                            n_large   = 1'b0;
                            n_limit   = clamp_lim(13'(r_scratch >> 1));
                            n_o_valid = 1'b1;
                            n_o_data  = '{wide: 1'b0, count: '0, blen: '0, length: '0,
                                          offset: '0, status: ST_OK};
                            n_state   = S_IDLE;
                        end
                    end
                    ACT_FINISH: begin
                        if (out_free) begin
                            n_o_valid = 1'b1;
                            n_o_data  = '{wide: r_large, count: r_count, blen: c_blen[23:0],
                                          length: '0, offset: '0, status: ST_OK};
                            n_state   = S_IDLE;
                        end
                    end
                    ACT_READ: begin
                        // fetch the following entry, it bounds the item's length
                        rd_en   = 1'b1;
                        rd_addr = to_addr(17'(r_idx) + 17'd1);
                        n_state = S_FIN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_FIN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (r_act == ACT_READ) begin
                        n_o_data = '{wide: r_large, count: r_count, blen: '0,
                                     length: f_bad ? '0 : f_len[23:0],
                                     offset: f_bad ? '0 : r_off0,
                                     status: f_bad ? ST_BAD_INDEX : ST_OK};
                    end else if (f_fail) begin
                        n_o_data = '{wide: r_large, count: r_count, blen: '0, length: '0,
                                     offset: '0, status: ST_NO_ROOM};
                    end else begin
                        // entries below the count are never rewritten, so no forwarding
                        wr_en     = ({4'b0, r_count} < DEPTH_V);
                        n_count   = r_count + 13'd1;
                        n_len_sum = r_new_sum[23:0];
                        if (!f_small && !r_large) begin
                            n_large = 1'b1;
                            n_limit = f_lim3;
                        end
                        n_o_data = '{wide: n_large, count: n_count, blen: '0, length: '0,
                                     offset: r_next_off[23:0], status: ST_OK};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_count   <= '0;
            r_len_sum <= '0;
            r_large   <= 1'b0;
            r_limit   <= LIMIT_RST;
            r_max_buf <= MAX_BUF_RST;
            r_scratch <= SCRATCH_RST;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_count   <= n_count;
            r_len_sum <= n_len_sum;
            r_large   <= n_large;
            r_limit   <= n_limit;
            if (cfg_wr) begin
                if (paddr[2] == REG_SCRATCH) begin
                    r_scratch <= pwdata[SCR_W-1:0];
                end else begin
                    r_max_buf <= pwdata[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_data <= n_o_data;
        if (accept) begin
            r_act  <= in_act;
            r_ilen <= s_axis_tdata[25:2];
            r_idx  <= in_idx;
        end
        if (r_state == S_CALC) begin
            r_next_off <= c_next_off;
            r_new_sum  <= c_new_sum;
            r_tail_s   <= c_tail_s;
            r_tail_w   <= c_tail_w;
            r_div3     <= c_prod[DIV3_SHIFT+CNT_W-1:DIV3_SHIFT];
            if (r_act == ACT_READ) begin
                r_off0 <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_next_off[23:0];
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_limit)
        else $error("item count above limit");

    a_wide_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_large && !start_commit) |=> r_large)
        else $error("wide mode dropped without a new block");

    a_sum_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!start_commit) |=> (r_len_sum >= $past(r_len_sum)))
        else $error("length sum went down without a new block");

    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CALC))
        else $error("accepted beat not taken into work");

endmodule
